/* hdl/stack_machine_execute_unit_defines.svh */
// assertion macros for the stack machine execute unit
// used by the top level only, no other dependencies
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMEU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smeu same-cycle check failed");

// next-cycle implication, checked outside reset
`define SMEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smeu next-cycle check failed");

`endif

/* hdl/smeu_pkg.sv */
// shared types, codes and default sizes of the stack machine execute unit
// no dependencies
`default_nettype none

package smeu_pkg;

  // default sizes
  localparam int DATA_STACK_DEPTH_DEF   = 64;
  localparam int RETURN_STACK_DEPTH_DEF = 16;
  localparam int MEMORY_WORDS_DEF       = 128;
  localparam int REGISTER_COUNT_DEF     = 5;
  // highest usable data memory size
  localparam int ADDR_LIMIT_BASE        = 100;

  // opcodes
  typedef enum logic [3:0] {
    OP_HLT   = 4'd0,
    OP_PUSH  = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_SQRT  = 4'd6,
    OP_OUT   = 4'd7,
    OP_POPR  = 4'd8,
    OP_PUSHR = 4'd9,
    OP_JMP   = 4'd10,
    OP_CALL  = 4'd11,
    OP_RET   = 4'd12,
    OP_PUSHM = 4'd13,
    OP_POPM  = 4'd14,
    OP_NOP   = 4'd15
  } op_t;

  // error codes
  typedef enum logic [3:0] {
    ERR_OK      = 4'd0,
    ERR_FULL    = 4'd1,
    ERR_EMPTY   = 4'd2,
    ERR_DIVZERO = 4'd3,
    ERR_NEGROOT = 4'd4,
    ERR_BADADDR = 4'd5,
    ERR_RFULL   = 4'd6,
    ERR_REMPTY  = 4'd7,
    ERR_BADREG  = 4'd8
  } err_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
    logic finish;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic long_op;
    logic iter_done;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/smeu_divsqrt.sv */
// iterative signed divider and integer square root, one bit or bit pair per cycle
// depends on nothing but its ports
`default_nettype none

module smeu_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        sqrt_mode,
  input  wire logic [31:0] opa,
  input  wire logic [31:0] opb,
  output logic [31:0]      result,
  output logic             done
);

  logic [31:0] acc;
  logic [31:0] dq;
  logic [31:0] dvs;
  logic [31:0] bt;
  logic [4:0]  cnt;
  logic        busy;
  logic        mode;
  logic        neg;

  logic [33:0] diff;
  logic        div_ge;
  logic [31:0] sq_sum;
  logic        sq_ge;

  // one restoring divide step and one root step
  always_comb begin
    diff   = {1'b0, acc, dq[31]} - {2'b00, dvs};
    div_ge = ~diff[33];
    sq_sum = dq + bt;
    sq_ge  = (acc >= sq_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mode <= sqrt_mode;
        bt   <= 32'h4000_0000;
        if (sqrt_mode) begin
          acc <= opa;
          dq  <= '0;
          cnt <= 5'd15;
          neg <= 1'b0;
        end else begin
          // magnitudes, sign restored at the end
          acc <= '0;
          dq  <= opb[31] ? (32'd0 - opb) : opb;
          dvs <= opa[31] ? (32'd0 - opa) : opa;
          neg <= opa[31] ^ opb[31];
          cnt <= 5'd31;
        end
      end else if (busy) begin
        if (mode) begin
          if (sq_ge) begin
            acc <= acc - sq_sum;
            dq  <= (dq >> 1) + bt;
          end else begin
            dq  <= dq >> 1;
          end
          bt <= bt >> 2;
        end else begin
          acc <= div_ge ? diff[31:0] : {acc[30:0], dq[31]};
          dq  <= {dq[30:0], div_ge};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (!mode && neg) ? (32'd0 - dq) : dq;

endmodule

`default_nettype wire

/* hdl/smeu_ctrl.sv */
// controller state machine of the stack machine execute unit
// depends on smeu_pkg for command and status structs
`default_nettype none

module smeu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          instr_valid,
  output logic               instr_stall,
  output logic               result_valid,
  input  wire logic          result_stall,
  input  wire smeu_pkg::sts_t sts,
  output smeu_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ITER,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  // output slot empty or being taken this cycle
  assign out_free = !result_valid || !result_stall;

  // commands decoded from state
  always_comb begin
    cmd.capture = (state == S_IDLE) && instr_valid;
    cmd.read    = (state == S_READ);
    cmd.exec    = (state == S_EXEC);
    cmd.finish  = (state == S_ITER) && sts.iter_done;
    cmd.emit    = (state == S_RESULT) && out_free;
  end

  assign instr_stall = (state != S_IDLE);

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (instr_valid) state <= S_READ;
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= sts.long_op ? S_ITER : S_RESULT;
        end
        S_ITER: begin
          if (sts.iter_done) state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/smeu_dpath.sv */
// datapath: stacks, registers, data memory, arithmetic and result registers
// depends on smeu_pkg and smeu_divsqrt
`default_nettype none

module smeu_dpath #(
  parameter int DATA_STACK_DEPTH   = smeu_pkg::DATA_STACK_DEPTH_DEF,
  parameter int RETURN_STACK_DEPTH = smeu_pkg::RETURN_STACK_DEPTH_DEF,
  parameter int MEMORY_WORDS       = smeu_pkg::MEMORY_WORDS_DEF,
  parameter int REGISTER_COUNT     = smeu_pkg::REGISTER_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire smeu_pkg::cmd_t cmd,
  output smeu_pkg::sts_t      sts,
  input  wire logic [3:0]     action,
  input  wire logic [31:0]    operand,
  input  wire logic [15:0]    current_address,
  output logic [3:0]          error_code,
  output logic                out_valid,
  output logic [31:0]         out_value,
  output logic                jump_taken,
  output logic [15:0]         jump_target,
  output logic                halted
);

  localparam int ADDR_LIMIT = (smeu_pkg::ADDR_LIMIT_BASE < MEMORY_WORDS) ?
                              smeu_pkg::ADDR_LIMIT_BASE : MEMORY_WORDS;
  localparam int DIW = $clog2(DATA_STACK_DEPTH);
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RIW = $clog2(RETURN_STACK_DEPTH);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int GIW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int AW  = $clog2(ADDR_LIMIT);

  // latched instruction
  smeu_pkg::op_t op_q;
  logic [31:0]   opnd_q;
  logic [15:0]   pc_q;

  // storage
  logic [31:0] ds_mem [DATA_STACK_DEPTH];
  logic [15:0] rs_mem [RETURN_STACK_DEPTH];
  logic [31:0] dm_mem [ADDR_LIMIT];
  logic [ADDR_LIMIT-1:0] dm_vld;
  logic [31:0] gregs  [REGISTER_COUNT];
  logic [DDW-1:0] dd;
  logic [RDW-1:0] rd;

  // registered read data
  logic [31:0] ds_top;
  logic [31:0] ds_nxt;
  logic [15:0] rs_top;
  logic [31:0] dm_rd;
  logic        dm_rd_v;

  // result registers, then output registers
  smeu_pkg::err_t r_err;
  logic        r_ov;
  logic [31:0] r_oval;
  logic        r_jt;
  logic [15:0] r_jtgt;
  logic        r_halt;

  logic [DDW-1:0] dd_m1;
  logic [DDW-1:0] dd_m2;
  logic        ds_full;
  logic        has1;
  logic        has2;
  logic        rs_full;
  logic        rs_has;
  logic        reg_ok;
  logic [31:0] reg_val;
  logic        ma_ok;
  logic [AW-1:0] ma_idx;
  logic [31:0] dm_val;
  logic [31:0] prod;

  // exec decisions
  smeu_pkg::err_t e_err;
  logic        e_ov;
  logic [31:0] e_oval;
  logic        e_jt;
  logic [15:0] e_jtgt;
  logic        e_halt;
  logic        ds_we;
  logic [DIW-1:0] ds_wa;
  logic [31:0] ds_wd;
  logic [DDW-1:0] dd_nx;
  logic        rs_we;
  logic [RDW-1:0] rd_nx;
  logic        reg_we;
  logic        dm_we;
  logic        long_op;

  // shared iterative unit
  logic [31:0] it_res;
  logic        it_done;

  // final write port selection
  logic        w_en;
  logic [DIW-1:0] w_addr;
  logic [31:0] w_data;

  smeu_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && long_op),
    .sqrt_mode(op_q == smeu_pkg::OP_SQRT),
    .opa      (ds_top),
    .opb      (ds_nxt),
    .result   (it_res),
    .done     (it_done)
  );

  // stack and register status
  always_comb begin
    dd_m1   = dd - DDW'(1);
    dd_m2   = dd - DDW'(2);
    ds_full = (dd == DDW'(DATA_STACK_DEPTH));
    has1    = (dd != '0);
    has2    = (dd >= DDW'(2));
    rs_full = (rd == RDW'(RETURN_STACK_DEPTH));
    rs_has  = (rd != '0);
    reg_ok  = (opnd_q < 32'(REGISTER_COUNT));
    reg_val = reg_ok ? gregs[opnd_q[GIW-1:0]] : 32'd0;
    ma_ok   = (reg_val < 32'(ADDR_LIMIT));
    ma_idx  = reg_val[AW-1:0];
    dm_val  = dm_rd_v ? dm_rd : 32'd0;
    prod    = ds_nxt * ds_top;
  end

  // per-opcode checks and state updates
  always_comb begin
    e_err   = smeu_pkg::ERR_OK;
    e_ov    = 1'b0;
    e_oval  = '0;
    e_jt    = 1'b0;
    e_jtgt  = '0;
    e_halt  = 1'b0;
    ds_we   = 1'b0;
    ds_wa   = dd[DIW-1:0];
    ds_wd   = opnd_q;
    dd_nx   = dd;
    rs_we   = 1'b0;
    rd_nx   = rd;
    reg_we  = 1'b0;
    dm_we   = 1'b0;
    long_op = 1'b0;
    unique case (op_q)
      smeu_pkg::OP_HLT: begin
        e_halt = 1'b1;
      end
      smeu_pkg::OP_PUSH: begin
        if (ds_full) e_err = smeu_pkg::ERR_FULL;
        else begin
          ds_we = 1'b1;
          dd_nx = dd + DDW'(1);
        end
      end
      smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL: begin
        if (!has2) e_err = smeu_pkg::ERR_EMPTY;
        else begin
          ds_we = 1'b1;
          ds_wa = dd_m2[DIW-1:0];
          dd_nx = dd_m1;
          if (op_q == smeu_pkg::OP_ADD) ds_wd = ds_nxt + ds_top;
          else if (op_q == smeu_pkg::OP_SUB) ds_wd = ds_nxt - ds_top;
          else ds_wd = prod;
        end
      end
      smeu_pkg::OP_DIV: begin
        if (!has2) e_err = smeu_pkg::ERR_EMPTY;
        else if (ds_top == 32'd0) e_err = smeu_pkg::ERR_DIVZERO;
        else long_op = 1'b1;
      end
      smeu_pkg::OP_SQRT: begin
        if (!has1) e_err = smeu_pkg::ERR_EMPTY;
        else if (ds_top[31]) e_err = smeu_pkg::ERR_NEGROOT;
        else long_op = 1'b1;
      end
      smeu_pkg::OP_OUT: begin
        if (!has1) e_err = smeu_pkg::ERR_EMPTY;
        else begin
          e_ov   = 1'b1;
          e_oval = ds_top;
          dd_nx  = dd_m1;
        end
      end
      smeu_pkg::OP_POPR: begin
        if (!reg_ok) e_err = smeu_pkg::ERR_BADREG;
        else if (!has1) e_err = smeu_pkg::ERR_EMPTY;
        else begin
          reg_we = 1'b1;
          dd_nx  = dd_m1;
        end
      end
      smeu_pkg::OP_PUSHR: begin
        if (!reg_ok) e_err = smeu_pkg::ERR_BADREG;
        else if (ds_full) e_err = smeu_pkg::ERR_FULL;
        else begin
          ds_we = 1'b1;
          ds_wd = reg_val;
          dd_nx = dd + DDW'(1);
        end
      end
      smeu_pkg::OP_JMP: begin
        e_jt   = 1'b1;
        e_jtgt = opnd_q[15:0];
      end
      smeu_pkg::OP_CALL: begin
        if (rs_full) e_err = smeu_pkg::ERR_RFULL;
        else begin
          rs_we  = 1'b1;
          rd_nx  = rd + RDW'(1);
          e_jt   = 1'b1;
          e_jtgt = opnd_q[15:0];
        end
      end
      smeu_pkg::OP_RET: begin
        if (!rs_has) e_err = smeu_pkg::ERR_REMPTY;
        else begin
          rd_nx  = rd - RDW'(1);
          e_jt   = 1'b1;
          e_jtgt = rs_top;
        end
      end
      smeu_pkg::OP_PUSHM: begin
        if (!reg_ok) e_err = smeu_pkg::ERR_BADREG;
        else if (!ma_ok) e_err = smeu_pkg::ERR_BADADDR;
        else if (ds_full) e_err = smeu_pkg::ERR_FULL;
        else begin
          ds_we = 1'b1;
          ds_wd = dm_val;
          dd_nx = dd + DDW'(1);
        end
      end
      smeu_pkg::OP_POPM: begin
        if (!reg_ok) e_err = smeu_pkg::ERR_BADREG;
        else if (!ma_ok) e_err = smeu_pkg::ERR_BADADDR;
        else if (!has1) e_err = smeu_pkg::ERR_EMPTY;
        else begin
          dm_we = 1'b1;
          dd_nx = dd_m1;
        end
      end
      smeu_pkg::OP_NOP: begin
        e_err = smeu_pkg::ERR_OK;
      end
      default: begin
        e_err = smeu_pkg::ERR_OK;
      end
    endcase
  end

  assign sts.long_op   = long_op;
  assign sts.iter_done = it_done;

  // data stack write port: exec result or iterative result
  always_comb begin
    if (cmd.finish) begin
      w_en   = 1'b1;
      w_addr = (op_q == smeu_pkg::OP_DIV) ? dd_m2[DIW-1:0] : dd_m1[DIW-1:0];
      w_data = it_res;
    end else begin
      w_en   = cmd.exec && ds_we;
      w_addr = ds_wa;
      w_data = ds_wd;
    end
  end

  // data stack memory, two registered reads
  always_ff @(posedge clk) begin
    if (w_en) ds_mem[w_addr] <= w_data;
    if (cmd.read) begin
      ds_top <= ds_mem[dd_m1[DIW-1:0]];
      ds_nxt <= ds_mem[dd_m2[DIW-1:0]];
    end
  end

  // return stack memory
  always_ff @(posedge clk) begin
    if (cmd.exec && rs_we) rs_mem[rd[RIW-1:0]] <= pc_q + 16'd2;
    if (cmd.read) rs_top <= rs_mem[rd[RIW-1:0] - RIW'(1)];
  end

  // data memory contents
  always_ff @(posedge clk) begin
    if (cmd.exec && dm_we) dm_mem[ma_idx] <= ds_top;
    if (cmd.read) dm_rd <= dm_mem[ma_idx];
  end

  // data memory valid bits, unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      dm_vld  <= '0;
      dm_rd_v <= 1'b0;
    end else begin
      if (cmd.exec && dm_we) dm_vld[ma_idx] <= 1'b1;
      if (cmd.read) dm_rd_v <= dm_vld[ma_idx];
    end
  end

  // instruction capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= smeu_pkg::op_t'(action);
      opnd_q <= operand;
      pc_q   <= current_address;
    end
  end

  // depths and general registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dd <= '0;
      rd <= '0;
      for (int i = 0; i < REGISTER_COUNT; i++) gregs[i] <= '0;
    end else begin
      if (cmd.exec) begin
        dd <= dd_nx;
        rd <= rd_nx;
        if (reg_we) gregs[opnd_q[GIW-1:0]] <= ds_top;
      end else if (cmd.finish && op_q == smeu_pkg::OP_DIV) begin
        dd <= dd_m1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_err  <= e_err;
      r_ov   <= e_ov;
      r_oval <= e_oval;
      r_jt   <= e_jt;
      r_jtgt <= e_jtgt;
      r_halt <= e_halt;
    end
  end

  // output word registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      error_code  <= r_err;
      out_valid   <= r_ov;
      out_value   <= r_oval;
      jump_taken  <= r_jt;
      jump_target <= r_jtgt;
      halted      <= r_halt;
    end
  end

endmodule

`default_nettype wire

/* hdl/stack_machine_execute_unit.sv */
// one instruction at a time: accept, stack read, execute, then the result word.
// div and sqrt without an error also wait in an iteration state for the shared iterative
// divide/root unit; all other instructions go straight from execute to the result word.
// the next instruction can be accepted in the cycle after the result word is registered.
// synchronous reset clears depths, general registers, memory valid bits and control.
`default_nettype none
`include "stack_machine_execute_unit_defines.svh"

module stack_machine_execute_unit #(
  parameter int DATA_STACK_DEPTH   = smeu_pkg::DATA_STACK_DEPTH_DEF,
  parameter int RETURN_STACK_DEPTH = smeu_pkg::RETURN_STACK_DEPTH_DEF,
  parameter int MEMORY_WORDS       = smeu_pkg::MEMORY_WORDS_DEF,
  parameter int REGISTER_COUNT     = smeu_pkg::REGISTER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        instr_valid,
  output logic             instr_stall,
  input  wire logic [3:0]  action,
  input  wire logic [31:0] operand,
  input  wire logic [15:0] current_address,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [3:0]       error_code,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             jump_taken,
  output logic [15:0]      jump_target,
  output logic             halted
);

  smeu_pkg::cmd_t cmd;
  smeu_pkg::sts_t sts;

  // controller
  smeu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath
  smeu_dpath #(
    .DATA_STACK_DEPTH  (DATA_STACK_DEPTH),
    .RETURN_STACK_DEPTH(RETURN_STACK_DEPTH),
    .MEMORY_WORDS      (MEMORY_WORDS),
    .REGISTER_COUNT    (REGISTER_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .operand        (operand),
    .current_address(current_address),
    .error_code     (error_code),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .jump_taken     (jump_taken),
    .jump_target    (jump_target),
    .halted         (halted)
  );

  // one instruction in flight: stall right after an accept
  `SMEU_ASSERT_NEXT(a_one_in_flight, clk, rst, instr_valid && !instr_stall, instr_stall)
  // an error word carries no side result
  `SMEU_ASSERT_SAME(a_err_clean, clk, rst, result_valid && error_code != smeu_pkg::ERR_OK, !out_valid && !jump_taken && !halted)
  // no out value without out_valid
  `SMEU_ASSERT_SAME(a_out_zero, clk, rst, result_valid && !out_valid, out_value == 32'd0)
  // no target without a jump
  `SMEU_ASSERT_SAME(a_jump_zero, clk, rst, result_valid && !jump_taken, jump_target == 16'd0)

endmodule

`default_nettype wire
